// ----- hdl/wra_pkg.sv -----
// Shared constants and types for the weight rank assigner.
package wra_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int ID_W      = 16;
    localparam int WT_W      = 32;
    localparam int RANK_W    = 7;

    typedef enum logic [1:0] {
        S_LOAD,
        S_FETCH,
        S_SWEEP,
        S_EMIT
    } wra_state_t;

    typedef enum logic {
        PH_PLACE,
        PH_MERGE
    } wra_phase_t;

endpackage

// ----- hdl/weight_rank_assigner.sv -----
// Weight rank assigner: loads a list, ranks by descending weight (on equal weight the item
// loaded first ranks higher), gives items sharing an id the largest of their ranks, and
// emits ranks in load order. Loading takes one cycle per transaction; in_ready is low from
// the last item until the final rank transaction is taken. Ranking makes two passes over
// the n stored items, each item sweeping the id/weight/rank memories through one read port.
// rst_n clears the control state and the item count; the memories are not cleared.
module weight_rank_assigner (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [wra_pkg::ID_W-1:0]   item_id,
    input  logic signed [wra_pkg::WT_W-1:0] item_weight,
    input  logic                       last_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [wra_pkg::ID_W-1:0]   out_id,
    output logic [wra_pkg::RANK_W-1:0] out_rank,
    output logic                       out_last
);
    import wra_pkg::*;

    logic [ID_W-1:0]        id_mem   [MAX_ITEMS];
    logic signed [WT_W-1:0] wt_mem   [MAX_ITEMS];
    logic [CNT_W-1:0]       rank_mem [MAX_ITEMS];

    wra_state_t             state_reg, state_next;
    wra_phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic [IDX_W-1:0]       jd_reg, jd_next;
    logic                   pend_reg, pend_next;
    logic                   cap_reg, cap_next;
    logic signed [WT_W-1:0] wi_reg, wi_next;
    logic [ID_W-1:0]        idi_reg, idi_next;
    logic [CNT_W-1:0]       acc_reg, acc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ID_W-1:0]        out_id_reg, out_id_next;
    logic [RANK_W-1:0]      out_rank_reg, out_rank_next;
    logic                   out_last_reg, out_last_next;

    logic [IDX_W-1:0]       rd_addr;
    logic [ID_W-1:0]        rd_id_reg;
    logic signed [WT_W-1:0] rd_wt_reg;
    logic [CNT_W-1:0]       rd_rank_reg;
    logic                   load_we;
    logic                   rank_we;
    logic                   in_take;
    logic                   is_final;

    assign in_ready  = (state_reg == S_LOAD);
    assign in_take   = in_valid && in_ready;
    assign load_we   = in_take && (count_reg < CNT_W'(MAX_ITEMS));
    assign is_final  = (CNT_W'(i_reg) + CNT_W'(1)) == n_reg;
    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_rank  = out_rank_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            id_mem[count_reg[IDX_W-1:0]] <= item_id;
            wt_mem[count_reg[IDX_W-1:0]] <= item_weight;
        end
        if (rank_we)
        begin
            rank_mem[i_reg] <= acc_reg;
        end
        rd_id_reg   <= id_mem[rd_addr];
        rd_wt_reg   <= wt_mem[rd_addr];
        rd_rank_reg <= rank_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            phase_reg     <= PH_PLACE;
            count_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            jd_reg        <= '0;
            pend_reg      <= 1'b0;
            cap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            jd_reg        <= jd_next;
            pend_reg      <= pend_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wi_reg       <= wi_next;
        idi_reg      <= idi_next;
        acc_reg      <= acc_next;
        out_id_reg   <= out_id_next;
        out_rank_reg <= out_rank_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jd_next        = jd_reg;
        pend_next      = 1'b0;
        cap_next       = 1'b0;
        wi_next        = wi_reg;
        idi_next       = idi_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_rank_next  = out_rank_reg;
        out_last_next  = out_last_reg;
        rank_we        = 1'b0;
        rd_addr        = i_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_take)
                begin
                    if (load_we)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_item)
                    begin
                        n_next     = load_we ? count_reg + CNT_W'(1) : count_reg;
                        phase_next = PH_PLACE;
                        i_next     = '0;
                        state_next = S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                rd_addr    = i_reg;
                j_next     = '0;
                cap_next   = 1'b1;
                state_next = S_SWEEP;
            end

            S_SWEEP:
            begin
                rd_addr = j_reg[IDX_W-1:0];
                if (cap_reg)
                begin
                    // item i's own entry lands this cycle
                    wi_next  = rd_wt_reg;
                    idi_next = rd_id_reg;
                    acc_next = (phase_reg == PH_PLACE) ? CNT_W'(1) : rd_rank_reg;
                end
                else if (pend_reg)
                begin
                    if (phase_reg == PH_PLACE)
                    begin
                        if (rd_wt_reg > wi_reg || (rd_wt_reg == wi_reg && jd_reg < i_reg))
                        begin
                            acc_next = acc_reg + CNT_W'(1);
                        end
                    end
                    else if (rd_id_reg == idi_reg && rd_rank_reg > acc_reg)
                    begin
                        acc_next = rd_rank_reg;
                    end
                end

                if (j_reg < n_reg)
                begin
                    pend_next = 1'b1;
                    jd_next   = j_reg[IDX_W-1:0];
                    j_next    = j_reg + CNT_W'(1);
                end
                else if (!pend_reg && !cap_reg)
                begin
                    if (phase_reg == PH_PLACE)
                    begin
                        rank_we = 1'b1;
                        if (is_final)
                        begin
                            phase_next = PH_MERGE;
                            i_next     = '0;
                        end
                        else
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = idi_reg;
                        out_rank_next  = RANK_W'(acc_reg);
                        out_last_next  = is_final;
                        state_next     = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule
